/* rtl/tcac_pkg.sv */
// Shared types, constants and helper functions for the text console core.
// No dependencies; every other file of the core imports this package.

package tcac_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int LIN_W      = ADDR_W + 1;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int Q_DEPTH    = 2;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] BLANK_BYTE = 8'h20;
  localparam logic [7:0] DEF_ATTR   = 8'h07;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_M       = 8'h6D;
  localparam logic [7:0] CH_J       = 8'h4A;
  localparam logic [7:0] CH_H       = 8'h48;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  char_byte;
    logic [10:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_linear;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
    logic [7:0]  active_attr;
  } out_t;

  typedef struct packed {
    logic is_read;
    logic is_esc;
    logic is_lbrack;
    logic is_digit;
    logic is_m;
    logic is_j;
    logic is_h;
  } class_t;

  typedef struct packed {
    in_t    word;
    class_t cls;
  } qent_t;

  function automatic logic [3:0] colour_map(input logic [2:0] idx, input logic bright);
    logic [3:0] c;
    unique case (idx)
      3'd0: c = 4'd0;
      3'd1: c = 4'd4;
      3'd2: c = 4'd2;
      3'd3: c = 4'd6;
      3'd4: c = 4'd1;
      3'd5: c = 4'd5;
      3'd6: c = 4'd3;
      default: c = 4'd7;
    endcase
    return {bright, c[2:0]};
  endfunction

  function automatic logic [7:0] set_colour(input logic [7:0] attr, input logic [7:0] code);
    logic [7:0] a;
    a = attr;
    if (code == 8'd0) begin
      a = DEF_ATTR;
    end else if (code >= 8'd30 && code <= 8'd37) begin
      a = {attr[7:4], colour_map(3'(code - 8'd30), 1'b0)};
    end else if (code >= 8'd90 && code <= 8'd97) begin
      a = {attr[7:4], colour_map(3'(code - 8'd90), 1'b1)};
    end
    return a;
  endfunction

  function automatic logic [LIN_W-1:0] lin_addr(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    return LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col);
  endfunction

endpackage

/* rtl/tcac_front.sv */
// Front end: accepts input words, classifies them and queues them.
// Depends on tcac_pkg.

module tcac_front
  import tcac_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  in_t   in_data,
  output logic  q_valid,
  input  logic  q_take,
  output qent_t q_ent
);

  qent_t      ent [Q_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  class_t     cls;

  always_comb begin
    cls.is_read   = (in_data.opcode == OP_READ);
    cls.is_esc    = (in_data.char_byte == ESC_BYTE);
    cls.is_lbrack = (in_data.char_byte == CH_LBRACK);
    cls.is_digit  = (in_data.char_byte >= CH_ZERO) && (in_data.char_byte <= CH_NINE);
    cls.is_m      = (in_data.char_byte == CH_M);
    cls.is_j      = (in_data.char_byte == CH_J);
    cls.is_h      = (in_data.char_byte == CH_H);
  end

  assign in_stall = (count == 2'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_ent    = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= '{word: in_data, cls: cls};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* rtl/tcac_back.sv */
// Back end: runs queued words against the screen memory, sequences scroll,
// clear and the reset fill, and holds the result register. Depends on tcac_pkg.

module tcac_back
  import tcac_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  input  qent_t q_ent,
  output logic  q_take,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_GLYPH = 6'b000100,
    S_COPY  = 6'b001000,
    S_FILL  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'b001,
    PH_ESC    = 3'b010,
    PH_CSI    = 3'b100
  } phase_t;

  logic [15:0] mem [CELL_COUNT];

  state_t            state, state_next;
  phase_t            phase, phase_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [7:0]        attr, attr_next;
  logic [7:0]        num, num_next;
  logic              pend_esc, pend_esc_next;
  logic              pend_lb, pend_lb_next;
  logic              pend_ch, pend_ch_next;
  logic [7:0]        ch, ch_next;
  logic              item_act, item_act_next;
  logic              rd_oob, rd_oob_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic              cp_wr;
  logic [ADDR_W-1:0] cp_addr;
  logic [15:0]       rdata;
  logic [7:0]        res_char, res_char_next;
  logic [7:0]        res_attr, res_attr_next;
  logic              out_valid_next;
  out_t              out_data_next;

  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [15:0]       wdata;

  logic [11:0]       acc;
  logic [7:0]        g;
  logic [7:0]        c8;
  logic [5:0]        r6;
  logic              st_we;
  logic [COL_W-1:0]  st_col;
  logic [7:0]        st_char;
  logic              need_scroll;
  logic              handled;

  assign acc = 12'(num) * 12'd10 + 12'(q_ent.word.char_byte[3:0]);

  always_comb begin
    g = pend_esc ? ESC_BYTE : (pend_lb ? CH_LBRACK : ch);
    c8      = 8'(col);
    r6      = 6'(row);
    st_we   = 1'b0;
    st_col  = col;
    st_char = g;
    if (g == CH_LF) begin
      c8 = 8'd0;
      r6 = r6 + 6'd1;
    end else if (g == CH_BS) begin
      if (col != '0) begin
        c8      = 8'(col) - 8'd1;
        st_we   = 1'b1;
        st_col  = col - COL_W'(1);
        st_char = BLANK_BYTE;
      end
    end else if (g == CH_TAB) begin
      c8 = (8'(col) + 8'd4) & 8'hFC;
    end else begin
      st_we = 1'b1;
      c8    = 8'(col) + 8'd1;
    end
    if (c8 >= 8'(COLUMNS)) begin
      c8 = 8'd0;
      r6 = r6 + 6'd1;
    end
    need_scroll = (r6 >= 6'(ROWS));
    if (need_scroll) begin
      r6 = 6'(ROWS - 1);
    end
  end

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    col_next       = col;
    row_next       = row;
    attr_next      = attr;
    num_next       = num;
    pend_esc_next  = pend_esc;
    pend_lb_next   = pend_lb;
    pend_ch_next   = pend_ch;
    ch_next        = ch;
    item_act_next  = item_act;
    rd_oob_next    = rd_oob;
    ptr_next       = ptr;
    res_char_next  = res_char;
    res_attr_next  = res_attr;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    q_take         = 1'b0;
    handled        = 1'b0;
    raddr          = ADDR_W'(q_ent.word.cell_index);

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_take        = 1'b1;
          item_act_next = 1'b1;
          ch_next       = q_ent.word.char_byte;
          pend_esc_next = 1'b0;
          pend_lb_next  = 1'b0;
          pend_ch_next  = 1'b0;
          res_char_next = 8'd0;
          res_attr_next = 8'd0;
          if (q_ent.cls.is_read) begin
            rd_oob_next = (32'(q_ent.word.cell_index) >= CELL_COUNT);
            state_next  = S_READ;
          end else begin
            if (phase == PH_ESC) begin
              phase_next = PH_NORMAL;
              if (q_ent.cls.is_lbrack) begin
                phase_next = PH_CSI;
                num_next   = 8'd0;
                handled    = 1'b1;
              end else begin
                pend_esc_next = 1'b1;
              end
            end else if (phase == PH_CSI) begin
              if (q_ent.cls.is_digit) begin
                num_next = (acc > 12'd255) ? 8'd255 : acc[7:0];
                handled  = 1'b1;
              end else begin
                phase_next = PH_NORMAL;
                if (q_ent.cls.is_m) begin
                  attr_next = set_colour(attr, num);
                  handled   = 1'b1;
                end else if (q_ent.cls.is_j && num == 8'd2) begin
                  col_next   = '0;
                  row_next   = '0;
                  ptr_next   = '0;
                  handled    = 1'b1;
                  state_next = S_FILL;
                end else if (q_ent.cls.is_h) begin
                  col_next = '0;
                  row_next = '0;
                  handled  = 1'b1;
                end else begin
                  pend_esc_next = 1'b1;
                  pend_lb_next  = 1'b1;
                end
              end
            end else begin
              phase_next = PH_NORMAL;
            end
            if (!handled) begin
              if (q_ent.cls.is_esc) begin
                phase_next = PH_ESC;
              end else begin
                pend_ch_next = 1'b1;
              end
            end
            if (state_next != S_FILL) begin
              if (pend_esc_next || pend_lb_next || pend_ch_next) begin
                state_next = S_GLYPH;
              end else begin
                state_next = S_DONE;
              end
            end
          end
        end
      end
      S_READ: begin
        res_char_next = rd_oob ? 8'd0 : rdata[7:0];
        res_attr_next = rd_oob ? 8'd0 : rdata[15:8];
        state_next    = S_DONE;
      end
      S_GLYPH: begin
        col_next = COL_W'(c8);
        row_next = ROW_W'(r6);
        if (pend_esc) begin
          pend_esc_next = 1'b0;
        end else if (pend_lb) begin
          pend_lb_next = 1'b0;
        end else begin
          pend_ch_next = 1'b0;
        end
        if (need_scroll) begin
          ptr_next   = '0;
          state_next = S_COPY;
        end else if ((pend_esc && (pend_lb || pend_ch)) || (!pend_esc && pend_lb && pend_ch)) begin
          state_next = S_GLYPH;
        end else begin
          state_next = S_DONE;
        end
      end
      S_COPY: begin
        raddr = ptr + ADDR_W'(COLUMNS);
        if (ptr == ADDR_W'(CELL_COUNT - COLUMNS - 1)) begin
          ptr_next   = ADDR_W'(CELL_COUNT - COLUMNS);
          state_next = S_FILL;
        end else begin
          ptr_next = ptr + ADDR_W'(1);
        end
      end
      S_FILL: begin
        if (!cp_wr) begin
          if (ptr == ADDR_W'(CELL_COUNT - 1)) begin
            if (pend_esc || pend_lb || pend_ch) begin
              state_next = S_GLYPH;
            end else if (item_act) begin
              state_next = S_DONE;
            end else begin
              state_next = S_IDLE;
            end
          end else begin
            ptr_next = ptr + ADDR_W'(1);
          end
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next              = 1'b1;
          out_data_next.cursor_column = 7'(col);
          out_data_next.cursor_row    = 5'(row);
          out_data_next.cursor_linear = 11'(lin_addr(row, col));
          out_data_next.read_char     = res_char;
          out_data_next.read_attr     = res_attr;
          out_data_next.active_attr   = attr;
          item_act_next               = 1'b0;
          state_next                  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = {attr, BLANK_BYTE};
    if (state == S_GLYPH && st_we) begin
      we    = 1'b1;
      waddr = ADDR_W'(lin_addr(row, st_col));
      wdata = {attr, st_char};
    end else if (cp_wr) begin
      we    = 1'b1;
      waddr = cp_addr;
      wdata = rdata;
    end else if (state == S_FILL) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    ch       <= ch_next;
    rd_oob   <= rd_oob_next;
    res_char <= res_char_next;
    res_attr <= res_attr_next;
    cp_addr  <= ptr;
    out_data <= out_data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      phase     <= PH_NORMAL;
      col       <= '0;
      row       <= '0;
      attr      <= DEF_ATTR;
      num       <= 8'd0;
      pend_esc  <= 1'b0;
      pend_lb   <= 1'b0;
      pend_ch   <= 1'b0;
      item_act  <= 1'b0;
      ptr       <= '0;
      cp_wr     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      col       <= col_next;
      row       <= row_next;
      attr      <= attr_next;
      num       <= num_next;
      pend_esc  <= pend_esc_next;
      pend_lb   <= pend_lb_next;
      pend_ch   <= pend_ch_next;
      item_act  <= item_act_next;
      ptr       <= ptr_next;
      cp_wr     <= (state == S_COPY);
      out_valid <= out_valid_next;
    end
  end

endmodule

/* rtl/text_console_with_ansi_colour_core.sv */
// Top level of the text console core: front queue plus execution back end.
// Depends on tcac_pkg, tcac_front and tcac_back.
//
//   channel  direction  handshake             word
//   in       into core  in_valid / in_stall   in_t  (opcode, char_byte, cell_index)
//   out      from core  out_valid / out_stall out_t (cursor, read cell, attribute)
//
// A read passes through S_READ and S_DONE in the back end, a plain put through
// S_GLYPH and S_DONE, and a swallowed escape byte through S_DONE alone; each held
// ESC or [ printed ahead of a byte adds a further S_GLYPH step. A put that moves
// past the last row runs a row copy (S_COPY) and bottom-row fill (S_FILL), and
// ESC [ 2 J a fill of all ROWS*COLUMNS cells. After reset the screen memory is
// filled first; words are queued during that time. A stalled output holds the
// back end only when a second result is ready; two input words queue meanwhile.

module text_console_with_ansi_colour_core
  import tcac_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic  q_valid;
  logic  q_take;
  qent_t q_ent;

  tcac_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_ent    (q_ent)
  );

  tcac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ent     (q_ent),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/tcac_checker.sv */
// Port-level checks for the text console core, bound to the top level.
// Depends on tcac_pkg and text_console_with_ansi_colour_core.

module tcac_checker
  import tcac_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Stalled output word was dropped.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("Stalled output word changed.");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(out_data.cursor_column) < COLUMNS) &&
                  (32'(out_data.cursor_row) < ROWS))
    else $error("Cursor outside the screen.");

  a_cursor_linear: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.cursor_linear ==
                  11'(lin_addr(ROW_W'(out_data.cursor_row), COL_W'(out_data.cursor_column))))
    else $error("Linear cursor does not match row and column.");

endmodule

bind text_console_with_ansi_colour_core tcac_checker u_tcac_checker (.*);

/* tb/tb_text_console_with_ansi_colour_core.sv */
// Testbench for the text console core: drives put and read words through the
// valid/stall channels and checks every result against an in-bench screen model.
// Depends on tcac_pkg and text_console_with_ansi_colour_core.
`timescale 1ns / 100ps

module tb_text_console_with_ansi_colour_core;
  import tcac_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  text_console_with_ansi_colour_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  typedef enum logic [1:0] {PH_TEXT, PH_ESC, PH_CSI} esc_phase_e;

  logic [15:0] screen [CELL_COUNT];
  int unsigned cur_col, cur_row;
  logic [7:0] cur_attr;
  esc_phase_e phase;
  int unsigned esc_num;
  out_t expected_words[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int scrolls = 0;
  int clears = 0;
  int stall_left = 0;

  function automatic logic [7:0] colour_of(int unsigned code, logic [7:0] attr);
    logic [3:0] lut [8];
    lut = '{4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7};
    if (code == 0) return DEF_ATTR;
    if (code >= 30 && code <= 37) return {attr[7:4], lut[code - 30]};
    if (code >= 90 && code <= 97) return {attr[7:4], lut[code - 90] | 4'd8};
    return attr;
  endfunction

  task automatic model_reset();
    for (int i = 0; i < CELL_COUNT; i++) screen[i] = {DEF_ATTR, BLANK_BYTE};
    cur_col = 0;
    cur_row = 0;
    cur_attr = DEF_ATTR;
    phase = PH_TEXT;
    esc_num = 0;
  endtask

  task automatic glyph(logic [7:0] ch);
    if (ch == CH_LF) begin
      cur_col = 0;
      cur_row++;
    end else if (ch == CH_BS) begin
      if (cur_col > 0) begin
        cur_col--;
        screen[cur_row * COLUMNS + cur_col] = {cur_attr, BLANK_BYTE};
      end
    end else if (ch == CH_TAB) begin
      cur_col = (cur_col + 4) & ~32'd3;
    end else begin
      screen[cur_row * COLUMNS + cur_col] = {cur_attr, ch};
      cur_col++;
    end
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) begin
      for (int i = 0; i < COLUMNS * (ROWS - 1); i++) screen[i] = screen[i + COLUMNS];
      for (int i = 0; i < COLUMNS; i++)
        screen[(ROWS - 1) * COLUMNS + i] = {cur_attr, BLANK_BYTE};
      cur_row = ROWS - 1;
      scrolls++;
    end
  endtask

  task automatic feed(logic [7:0] ch);
    if (phase == PH_ESC) begin
      phase = PH_TEXT;
      if (ch == CH_LBRACK) begin
        phase = PH_CSI;
        esc_num = 0;
        return;
      end
      glyph(ESC_BYTE);
    end else if (phase == PH_CSI) begin
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        esc_num = esc_num * 10 + (ch - CH_ZERO);
        if (esc_num > 255) esc_num = 255;
        return;
      end
      phase = PH_TEXT;
      if (ch == CH_M) begin
        cur_attr = colour_of(esc_num, cur_attr);
        return;
      end
      if (ch == CH_J && esc_num == 2) begin
        for (int i = 0; i < CELL_COUNT; i++) screen[i] = {cur_attr, BLANK_BYTE};
        cur_col = 0;
        cur_row = 0;
        clears++;
        return;
      end
      if (ch == CH_H) begin
        cur_col = 0;
        cur_row = 0;
        return;
      end
      glyph(ESC_BYTE);
      glyph(CH_LBRACK);
    end
    if (ch == ESC_BYTE) phase = PH_ESC;
    else glyph(ch);
  endtask

  task automatic predict_console(in_t w);
    out_t r;
    r = '0;
    if (w.opcode == OP_READ) begin
      if (w.cell_index < CELL_COUNT) begin
        r.read_char = screen[w.cell_index][7:0];
        r.read_attr = screen[w.cell_index][15:8];
      end
    end else begin
      feed(w.char_byte);
    end
    r.cursor_column = cur_col[6:0];
    r.cursor_row = cur_row[4:0];
    r.cursor_linear = 11'(cur_row * COLUMNS + cur_col);
    r.active_attr = cur_attr;
    expected_words.push_back(r);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_word(logic op, logic [7:0] ch, logic [10:0] idx);
    in_t w;
    int gap;
    w.opcode = op;
    w.char_byte = ch;
    w.cell_index = idx;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_console(w);
    words_sent++;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_byte(logic [7:0] ch);
    send_word(OP_PUT, ch, 11'($urandom));
  endtask

  task automatic read_cell(logic [10:0] idx);
    send_word(OP_READ, 8'($urandom), idx);
  endtask

  task automatic put_csi(int unsigned num, logic [7:0] final_byte);
    string s;
    s = $sformatf("%0d", num);
    put_byte(ESC_BYTE);
    put_byte(CH_LBRACK);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    put_byte(final_byte);
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_BS);
    put_byte(CH_TAB);
    put_byte(8'h41);
    put_byte(CH_LF);
    put_byte(CH_BS);
    read_cell(11'd0);
    read_cell(11'd1);
    read_cell(11'(CELL_COUNT - 1));
    read_cell(11'h7FF);
    put_csi(34, CH_M);
    put_csi(95, CH_M);
    put_csi(50, CH_M);
    put_csi(0, CH_M);
    put_csi(999, CH_M);
    put_byte(ESC_BYTE);
    put_byte(8'h78);
    put_byte(ESC_BYTE);
    put_byte(ESC_BYTE);
    put_byte(CH_LBRACK);
    put_byte(CH_H);
    put_csi(3, CH_J);
    put_csi(7, CH_H);
    put_csi(2, CH_J);
  endtask

  task automatic test_wrap_and_scroll();
    for (int i = 0; i < COLUMNS + 3; i++) put_byte(8'($urandom_range(32, 126)));
    for (int i = 0; i < ROWS + 2; i++) put_byte(CH_LF);
    read_cell(11'((ROWS - 1) * COLUMNS));
  endtask

  function automatic logic [7:0] random_text();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8) return CH_LF;
    if (p < 13) return CH_BS;
    if (p < 18) return CH_TAB;
    if (p < 22) return ESC_BYTE;
    if (p < 30) return 8'($urandom);
    return 8'($urandom_range(32, 126));
  endfunction

  task automatic test_random(int n);
    int p;
    int codes [6];
    codes = '{0, 31, 37, 90, 97, 44};
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 999);
      if (p < 250) read_cell(p < 20 ? 11'($urandom) : 11'($urandom_range(0, CELL_COUNT - 1)));
      else if (p < 330) put_csi($urandom_range(0, 1) ? codes[$urandom_range(0, 5)]
                                : $urandom_range(0, 300), CH_M);
      else if (p < 334) put_csi(2, CH_J);
      else if (p < 344) put_csi($urandom_range(0, 12), CH_H);
      else if (p < 360) put_csi($urandom_range(0, 40), random_text());
      else put_byte(random_text());
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          if (out_data !== expected_words[0]) begin
            $display("%0t: mismatch expected %p actual %p", $time, expected_words[0],
                     out_data);
            errors++;
          end
          void'(expected_words.pop_front());
          words_checked++;
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = gap_len();
      end
    end
  end

  initial begin
    model_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_wrap_and_scroll();
    test_random(1100);
    in_valid <= 1'b0;
    wait_drained();
    repeat (50) @(posedge clk);
    $display("Sent %0d words, checked %0d results, %0d scrolls and %0d clears.",
             words_sent, words_checked, scrolls, clears);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
